/* rtl/core/rdsm_pkg.sv */
// rdsm_pkg: constants, codes and the per-lane request type of the
// region-decoded sized memory. No dependencies.
package rdsm_pkg;

  // address split
  localparam int ADDR_BITS   = 32;
  localparam int OFFSET_BITS = 20;
  localparam int SEL_BITS    = ADDR_BITS - OFFSET_BITS;
  localparam int LANES       = 4;
  localparam int LANE_BITS   = 2;
  localparam int ROW_BITS    = OFFSET_BITS - LANE_BITS;
  localparam int REGION_BITS = 2;
  localparam int RAM_ABITS   = REGION_BITS + ROW_BITS;
  localparam int RAM_DEPTH   = 1 << RAM_ABITS;

  // region selects in the top address bits
  localparam logic [SEL_BITS-1:0] SEL_PROGRAM = SEL_BITS'(12'h004);
  localparam logic [SEL_BITS-1:0] SEL_DATA    = SEL_BITS'(12'h100);
  localparam logic [SEL_BITS-1:0] SEL_STACK   = SEL_BITS'(12'h800);

  // region codes inside each lane memory
  localparam logic [REGION_BITS-1:0] REGION_PROGRAM = 2'd0;
  localparam logic [REGION_BITS-1:0] REGION_DATA    = 2'd1;
  localparam logic [REGION_BITS-1:0] REGION_STACK   = 2'd2;

  // access kinds and sizes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;
  localparam logic [1:0] SIZE_BAD  = 2'd3;

  // status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_UNMAPPED = 2'd1;
  localparam logic [1:0] STATUS_BAD_SIZE = 2'd2;

  // one byte-lane memory request
  typedef struct packed {
    logic                 en;
    logic                 we;
    logic [RAM_ABITS-1:0] addr;
    logic [7:0]           wdata;
    logic [1:0]           pos;   // byte position in the result, 0 is least significant
  } lane_req_t;

endpackage

/* rtl/core/rdsm_ram.sv */
// rdsm_ram: generic single-port synchronous RAM with registered read.
// No dependencies.
module rdsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write or registered read, one access a cycle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

/* rtl/core/rdsm_lane_map.sv */
// rdsm_lane_map: spreads one sized big-endian access over the four byte lanes.
// Depends on rdsm_pkg.
module rdsm_lane_map (
  input  logic                                        go,
  input  logic                                        op,
  input  logic [1:0]                                  size,
  input  logic [rdsm_pkg::REGION_BITS-1:0]            region,
  input  logic [rdsm_pkg::OFFSET_BITS-1:0]            offset,
  input  logic [31:0]                                 write_data,
  output rdsm_pkg::lane_req_t [rdsm_pkg::LANES-1:0]   req
);
  import rdsm_pkg::*;

  logic [LANE_BITS-1:0] lane0;
  logic [ROW_BITS-1:0]  row0;
  logic [1:0]           last;

  assign lane0 = offset[LANE_BITS-1:0];
  assign row0  = offset[OFFSET_BITS-1:LANE_BITS];

  // index of the last byte of the access
  always_comb begin
    case (size)
      SIZE_BYTE: last = 2'd0;
      SIZE_HALF: last = 2'd1;
      default:   last = 2'd3;
    endcase
  end

  // byte i of the access sits in lane (offset + i) mod 4; lanes below the
  // start lane hold bytes that carried into the next row (wraps in region)
  always_comb begin
    logic [LANE_BITS-1:0] idx;
    logic [LANE_BITS-1:0] pos;
    logic [ROW_BITS-1:0]  row;
    for (int l = 0; l < LANES; l++) begin
      idx = LANE_BITS'(l) - lane0;
      pos = last - idx;
      row = row0 + ROW_BITS'(LANE_BITS'(l) < lane0);
      req[l].en    = go && (idx <= last);
      req[l].we    = (op == OP_WRITE);
      req[l].addr  = {region, row};
      req[l].wdata = 8'(write_data >> {pos, 3'b000});
      req[l].pos   = pos;
    end
  end

endmodule

/* rtl/core/region_decoded_sized_memory.sv */
// region_decoded_sized_memory: top level of the big-endian byte/half/word memory
// with three address regions. Depends on rdsm_pkg, rdsm_lane_map, rdsm_ram.
//
//   channel   | handshake        | signals
//   ----------+------------------+-----------------------------------
//   request   | start / busy     | op, address, write_data, size
//   result    | done (strobe)    | read_data, status
//
// A request is taken in any cycle with start high; busy stays low, so one
// request per cycle is sustained. The result strobes done in the cycle after the
// request, in step with the registered read of the four byte-lane memories.
// Reset clears only the result strobe; memory contents are undefined until
// written. The receiver cannot stall: each result is valid for one cycle.
module region_decoded_sized_memory (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [31:0] address,
  input  logic [31:0] write_data,
  input  logic [1:0]  size,
  output logic        done,
  output logic [31:0] read_data,
  output logic [1:0]  status
);
  import rdsm_pkg::*;

  logic                        accept;
  logic [SEL_BITS-1:0]         sel;
  logic [REGION_BITS-1:0]      region;
  logic                        mapped;
  logic                        go;
  logic [1:0]                  status_next;
  lane_req_t [LANES-1:0]       req;
  logic [LANES-1:0][7:0]       lane_q;
  logic [LANES-1:0]            rd_en;
  logic [LANES-1:0][1:0]       rd_pos;
  logic [LANES-1:0]            req_en;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign sel    = address[ADDR_BITS-1:OFFSET_BITS];

  // region decode
  always_comb begin
    mapped = 1'b1;
    region = REGION_PROGRAM;
    if (sel == SEL_PROGRAM) begin
      region = REGION_PROGRAM;
    end else if (sel == SEL_DATA) begin
      region = REGION_DATA;
    end else if (sel == SEL_STACK) begin
      region = REGION_STACK;
    end else begin
      mapped = 1'b0;
    end
  end

  // status: unmapped region wins over bad size
  always_comb begin
    if (!mapped) begin
      status_next = STATUS_UNMAPPED;
    end else if (size == SIZE_BAD) begin
      status_next = STATUS_BAD_SIZE;
    end else begin
      status_next = STATUS_OK;
    end
  end

  assign go = accept && (status_next == STATUS_OK);

  rdsm_lane_map u_lane_map (
    .go         (go),
    .op         (op),
    .size       (size),
    .region     (region),
    .offset     (address[OFFSET_BITS-1:0]),
    .write_data (write_data),
    .req        (req)
  );

  // one byte-lane memory per lane, all regions stacked by region code
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign req_en[l] = req[l].en;

    rdsm_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
    ) u_ram (
      .clk   (clk),
      .en    (req[l].en),
      .we    (req[l].we),
      .addr  (req[l].addr),
      .wdata (req[l].wdata),
      .rdata (lane_q[l])
    );
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  // result side info, held alongside the memory read
  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      for (int l = 0; l < LANES; l++) begin
        rd_en[l]  <= req[l].en && !req[l].we;
        rd_pos[l] <= req[l].pos;
      end
    end
  end

  // big-endian assembly of the lane bytes, zero for writes and errors
  always_comb begin
    read_data = '0;
    for (int l = 0; l < LANES; l++) begin
      if (rd_en[l]) begin
        read_data = read_data | ({24'b0, lane_q[l]} << {rd_pos[l], 3'b000});
      end
    end
  end

  // checks

  a_done_follows_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start))
    else $error("result strobe without a request");

  a_error_reads_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != STATUS_OK |-> read_data == 32'd0)
    else $error("error result carries data");

  a_write_reads_zero: assert property (@(posedge clk) disable iff (rst)
    done && $past(op) == OP_WRITE |-> read_data == 32'd0)
    else $error("write result carries data");

  a_lane_count: assert property (@(posedge clk) disable iff (rst)
    go |-> $countones(req_en) == ((size == SIZE_BYTE) ? 1 :
                                  (size == SIZE_HALF) ? 2 : 4))
    else $error("lane enables do not match access size");

endmodule

/* dv/sized_memory_checker.sv */
// sized_memory_checker: watches the request and result channels of the
// region-decoded sized memory, predicts each result and compares it.
// Depends on rdsm_pkg.
module sized_memory_checker
  import rdsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        op,
  input  logic [31:0] address,
  input  logic [31:0] write_data,
  input  logic [1:0]  size,
  input  logic        done,
  input  logic [31:0] read_data,
  input  logic [1:0]  status,
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
  } access_result_t;

  // shadow of all three regions, keyed by region select and byte offset
  logic [7:0]     shadow_bytes [bit [31:0]];
  access_result_t pending_results [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // apply one access to the shadow and return the result it should produce
  function automatic access_result_t apply_access(input logic        is_write,
                                                  input logic [31:0] addr,
                                                  input logic [31:0] wdata,
                                                  input logic [1:0]  sz);
    access_result_t         res;
    logic [SEL_BITS-1:0]    sel;
    logic [OFFSET_BITS-1:0] ofs;
    bit [31:0]              key;
    int                     nbytes;
    int                     i;
    res.read_data = '0;
    res.status    = STATUS_OK;
    sel = addr[ADDR_BITS-1:OFFSET_BITS];
    ofs = addr[OFFSET_BITS-1:0];
    // region decode takes priority over the size check
    if (sel != SEL_PROGRAM && sel != SEL_DATA && sel != SEL_STACK) begin
      res.status = STATUS_UNMAPPED;
      return res;
    end
    if (sz == SIZE_BAD) begin
      res.status = STATUS_BAD_SIZE;
      return res;
    end
    nbytes = 1 << sz;
    // big-endian: byte at the offset is most significant, offset wraps in region
    for (i = 0; i < nbytes; i++) begin
      key = {sel, OFFSET_BITS'(ofs + OFFSET_BITS'(i))};
      if (is_write == OP_WRITE)
        shadow_bytes[key] = wdata[8*(nbytes-1-i) +: 8];
      else
        res.read_data = {res.read_data[23:0],
                         shadow_bytes.exists(key) ? shadow_bytes[key] : 8'h00};
    end
    return res;
  endfunction

  // retire results first, then queue the prediction for a new request
  always @(posedge clk) begin
    access_result_t exp_res;
    if (rst) begin
      pending_results.delete();
    end else begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: read_data %h status %0d",
                 read_data, status);
          fail_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (read_data !== exp_res.read_data) begin
            $error("read_data mismatch: expected %h, got %h", exp_res.read_data, read_data);
            fail_count++;
          end
          if (status !== exp_res.status) begin
            $error("status mismatch: expected %0d, got %0d", exp_res.status, status);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        pending_results.push_back(apply_access(op, address, write_data, size));
    end
    outstanding = pending_results.size();
  end

endmodule

/* dv/tb_top.sv */
// tb_top: stimulus and verdict for region_decoded_sized_memory; results are
// predicted and checked by sized_memory_checker. Depends on rdsm_pkg.
module tb_top;
  import rdsm_pkg::*;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int DRAIN_CYCLES   = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        op = OP_READ;
  logic [31:0] address = '0;
  logic [31:0] write_data = '0;
  logic [1:0]  size = SIZE_BYTE;
  logic        busy;
  logic        done;
  logic [31:0] read_data;
  logic [1:0]  status;
  int          fail_count;
  int          outstanding;
  int          quiet_cycles = 0;

  // bytes written so far, so that reads only touch defined memory
  bit        written_map [bit [31:0]];
  bit [31:0] written_list [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  region_decoded_sized_memory u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .address    (address),
    .write_data (write_data),
    .size       (size),
    .done       (done),
    .read_data  (read_data),
    .status     (status)
  );

  sized_memory_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .address     (address),
    .write_data  (write_data),
    .size        (size),
    .done        (done),
    .read_data   (read_data),
    .status      (status),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  function automatic bit is_mapped(input logic [31:0] a);
    return a[ADDR_BITS-1:OFFSET_BITS] == SEL_PROGRAM ||
           a[ADDR_BITS-1:OFFSET_BITS] == SEL_DATA ||
           a[ADDR_BITS-1:OFFSET_BITS] == SEL_STACK;
  endfunction

  // address of the i-th byte of an access, wrapping inside the region
  function automatic bit [31:0] byte_at(input logic [31:0] a, input int i);
    return {a[ADDR_BITS-1:OFFSET_BITS],
            OFFSET_BITS'(a[OFFSET_BITS-1:0] + OFFSET_BITS'(i))};
  endfunction

  function automatic logic [31:0] region_addr(input int unsigned r,
                                              input logic [OFFSET_BITS-1:0] ofs);
    case (r)
      0:       return {SEL_PROGRAM, ofs};
      1:       return {SEL_DATA, ofs};
      default: return {SEL_STACK, ofs};
    endcase
  endfunction

  // present one request and return at the edge that accepts it
  task automatic issue(input logic o, input logic [31:0] a, input logic [31:0] d,
                       input logic [1:0] s);
    int i;
    start      <= 1'b1;
    op         <= o;
    address    <= a;
    write_data <= d;
    size       <= s;
    if (o == OP_WRITE && is_mapped(a) && s != SIZE_BAD) begin
      for (i = 0; i < (1 << s); i++) begin
        if (!written_map.exists(byte_at(a, i))) begin
          written_map[byte_at(a, i)] = 1'b1;
          written_list.push_back(byte_at(a, i));
        end
      end
    end
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  // hold off new requests until every expected result has come back
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // random traffic: mostly writes and reads of defined bytes, some error cases
  task automatic run_phase(input int count, input int idle_pct);
    int          k;
    int          kind;
    int          mode;
    int          j;
    bit          fits;
    logic        o;
    logic [31:0] a;
    logic [1:0]  s;
    logic [OFFSET_BITS-1:0] ofs;
    for (k = 0; k < count; k++) begin
      kind = $urandom_range(0, 99);
      if (kind >= 45 && kind < 85 && written_list.size() == 0)
        kind = 0;
      o = OP_WRITE;
      s = 2'($urandom_range(0, 2));
      // offsets cluster at the region start and end to get read hits and wrap
      mode = $urandom_range(0, 9);
      if (mode < 4)
        ofs = OFFSET_BITS'($urandom_range(0, 63));
      else if (mode < 6)
        ofs = {OFFSET_BITS{1'b1}} - OFFSET_BITS'($urandom_range(0, 63));
      else
        ofs = OFFSET_BITS'($urandom());
      if (kind < 45) begin
        a = region_addr($urandom_range(0, 2), ofs);
      end else if (kind < 85) begin
        // read starting on a written byte, shrunk until every byte is defined
        o = OP_READ;
        a = written_list[$urandom_range(0, written_list.size() - 1)];
        do begin
          fits = 1'b1;
          for (j = 0; j < (1 << s); j++)
            if (!written_map.exists(byte_at(a, j)))
              fits = 1'b0;
          if (!fits)
            s = s - 2'd1;
        end while (!fits);
      end else if (kind < 93) begin
        o = 1'($urandom());
        s = 2'($urandom());
        if ($urandom_range(0, 1) == 0) begin
          do a = $urandom(); while (is_mapped(a));
        end else begin
          // one select bit away from a mapped region
          a = region_addr($urandom_range(0, 2), ofs);
          a[ADDR_BITS-1:OFFSET_BITS] = a[ADDR_BITS-1:OFFSET_BITS] ^
                                       (SEL_BITS'(1) << $urandom_range(0, SEL_BITS - 1));
        end
      end else begin
        o = 1'($urandom());
        s = SIZE_BAD;
        a = region_addr($urandom_range(0, 2), ofs);
      end
      issue(o, a, $urandom(), s);
      // idle cycle by cycle with junk on the payload while start is low
      while ($urandom_range(0, 99) < idle_pct) begin
        start      <= 1'b0;
        op         <= 1'($urandom());
        address    <= $urandom();
        write_data <= $urandom();
        size       <= 2'($urandom());
        @(posedge clk);
      end
    end
  endtask

  // watchdog on cycles where neither channel moves
  always @(posedge clk) begin
    if (rst || (start && !busy) || done)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: aligned and unaligned sizes, wrap at the region end
    issue(OP_WRITE, 32'h0040_0000, 32'hDEAD_BEEF, SIZE_WORD);
    issue(OP_READ,  32'h0040_0000, $urandom(),    SIZE_WORD);
    issue(OP_READ,  32'h0040_0001, $urandom(),    SIZE_HALF);
    issue(OP_READ,  32'h0040_0003, $urandom(),    SIZE_BYTE);
    issue(OP_WRITE, 32'h0040_0004, 32'h0123_4567, SIZE_WORD);
    issue(OP_READ,  32'h0040_0002, $urandom(),    SIZE_WORD);
    issue(OP_WRITE, 32'h100F_FFFE, 32'hA5A5_5A5A, SIZE_WORD);
    issue(OP_READ,  32'h100F_FFFF, $urandom(),    SIZE_HALF);
    issue(OP_READ,  32'h1000_0000, $urandom(),    SIZE_BYTE);
    issue(OP_WRITE, 32'h800F_FFFF, 32'hFFFF_FFFF, SIZE_BYTE);
    issue(OP_READ,  32'h800F_FFFF, $urandom(),    SIZE_BYTE);
    issue(OP_WRITE, 32'h8000_0000, 32'h0000_C3A5, SIZE_HALF);
    issue(OP_READ,  32'h800F_FFFF, $urandom(),    SIZE_HALF);
    issue(OP_WRITE, 32'h1001_0000, 32'h0000_0000, SIZE_WORD);
    issue(OP_READ,  32'h1001_0000, $urandom(),    SIZE_WORD);
    // unmapped selects, checked ahead of the size
    issue(OP_READ,  32'h0000_0000, $urandom(),    SIZE_WORD);
    issue(OP_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SIZE_BAD);
    issue(OP_READ,  32'h0030_0000, $urandom(),    SIZE_BYTE);
    issue(OP_WRITE, 32'h8010_0000, 32'h1234_5678, SIZE_WORD);
    // bad size in a mapped region must leave memory alone
    issue(OP_WRITE, 32'h0040_0000, 32'h1111_1111, SIZE_BAD);
    issue(OP_READ,  32'h0040_0000, $urandom(),    SIZE_BAD);
    issue(OP_READ,  32'h0040_0000, $urandom(),    SIZE_WORD);
    drain();

    run_phase(250, 35);
    drain();
    run_phase(250, 55);
    drain();
    run_phase(250, 0);

    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
